// ===== rtl/core/assert_macros.svh =====
// Assertion macros for RTL files that check their own logic.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ptd_pkg.sv =====
// Package for the poly-A tail detector: payload structs, codes, config defaults,
// control word layout and the microcode program. No dependencies.
`default_nettype none

package ptd_pkg;

  localparam int unsigned ADDR_BITS_DEF = 20;

  localparam int unsigned POS_W      = 20;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned SHIFT_W    = 10;
  localparam int unsigned RCNT_W     = 4;
  localparam int unsigned MINLEN_W   = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PC_W       = 4;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_SHIFT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_COUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPEAT_LEN = 2'd3;

  localparam logic [THR_W-1:0]    THR_RST    = 10'd16;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 10'd20;
  localparam logic [RCNT_W-1:0]   RCNT_RST   = 4'd8;
  localparam logic [MINLEN_W-1:0] MINLEN_RST = 20'd1000;

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_T_LO = 8'h74;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       base;
    logic [POS_W-1:0] rep_start;
    logic [POS_W-1:0] rep_end;
    logic             strand;
  } in_t;

  typedef struct packed {
    logic is_long;
    logic has_tail;
    logic overflowed;
  } out_t;

  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_QUERY   = 3'd2,
    C_FLAG       = 3'd3,
    C_NOT_LONG   = 3'd4,
    C_TAIL       = 3'd5,
    C_RETRY_DONE = 3'd6,
    C_OUT_BUSY   = 3'd7
  } cond_e;

  typedef enum logic [1:0] {
    P_HOLD      = 2'd0,
    P_STEP      = 2'd1,
    P_STEP_FLAG = 2'd2
  } pos_op_e;

  typedef struct packed {
    cond_e          cond;
    logic [PC_W-1:0] target;
    logic           accept;
    logic           init;
    logic           rd_en;
    logic           rd_hi;
    pos_op_e        lo_op;
    pos_op_e        hi_op;
    logic           chk;
    logic           retry;
    logic           emit;
  } ctl_t;

  typedef struct packed {
    logic query_acc;
    logic is_long;
    logic flag;
    logic tail_hit;
    logic retry_done;
    logic out_busy;
  } stat_t;

  localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] ST_INIT  = 4'd1;
  localparam logic [PC_W-1:0] ST_LO1_R = 4'd2;
  localparam logic [PC_W-1:0] ST_LO1_T = 4'd3;
  localparam logic [PC_W-1:0] ST_LO2_R = 4'd4;
  localparam logic [PC_W-1:0] ST_LO2_T = 4'd5;
  localparam logic [PC_W-1:0] ST_HI1_R = 4'd6;
  localparam logic [PC_W-1:0] ST_HI1_T = 4'd7;
  localparam logic [PC_W-1:0] ST_HI2_R = 4'd8;
  localparam logic [PC_W-1:0] ST_HI2_T = 4'd9;
  localparam logic [PC_W-1:0] ST_CHK   = 4'd10;
  localparam logic [PC_W-1:0] ST_RDONE = 4'd11;
  localparam logic [PC_W-1:0] ST_SHIFT = 4'd12;
  localparam logic [PC_W-1:0] ST_EMIT  = 4'd15;

  localparam ctl_t CTL_NOP = '{cond: C_NEXT, target: ST_IDLE, accept: 1'b0, init: 1'b0,
                               rd_en: 1'b0, rd_hi: 1'b0, lo_op: P_HOLD, hi_op: P_HOLD,
                               chk: 1'b0, retry: 1'b0, emit: 1'b0};

  // Program: false condition falls through to pc + 1; the emit step wraps to idle.
  function automatic ctl_t ucode(logic [PC_W-1:0] pc);
    ctl_t c;
    c = CTL_NOP;
    unique case (pc) inside
      ST_IDLE: begin
        c.cond = C_NO_QUERY; c.target = ST_IDLE; c.accept = 1'b1;
      end
      ST_INIT: begin
        c.cond = C_NOT_LONG; c.target = ST_EMIT; c.init = 1'b1;
      end
      ST_LO1_R, ST_LO2_R: begin
        c.rd_en = 1'b1;
      end
      ST_LO1_T: begin
        c.cond = C_FLAG; c.target = ST_LO1_R; c.lo_op = P_STEP;
      end
      ST_LO2_T: begin
        c.cond = C_FLAG; c.target = ST_LO2_R; c.lo_op = P_STEP_FLAG;
      end
      ST_HI1_R, ST_HI2_R: begin
        c.rd_en = 1'b1; c.rd_hi = 1'b1;
      end
      ST_HI1_T: begin
        c.cond = C_FLAG; c.target = ST_HI1_R; c.hi_op = P_STEP;
      end
      ST_HI2_T: begin
        c.cond = C_FLAG; c.target = ST_HI2_R; c.hi_op = P_STEP_FLAG;
      end
      ST_CHK: begin
        c.cond = C_TAIL; c.target = ST_EMIT; c.chk = 1'b1;
      end
      ST_RDONE: begin
        c.cond = C_RETRY_DONE; c.target = ST_EMIT;
      end
      ST_SHIFT: begin
        c.cond = C_ALWAYS; c.target = ST_INIT; c.retry = 1'b1;
      end
      ST_EMIT: begin
        c.cond = C_OUT_BUSY; c.target = ST_EMIT; c.emit = 1'b1;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/polya_tail_detector.sv =====
// Top level of the poly-A tail detector: sequencer, datapath and A/T flag store.
// Depends on ptd_pkg, ptd_sequencer, ptd_datapath, ptd_flag_mem, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Load and restart beats keep the sequencer in its idle step, ready for the next beat; a
// query that is not long passes through the init and emit steps before the next beat is
// accepted. A long query runs a microcoded walk over the flag store, whose single
// registered read port needs a read step and a test step for each probed position; each
// search attempt probes the two A/T runs on each side of the anchor plus four boundary
// positions, and each retry adds a step for the anchor move. The result sits in an output
// register, so the next query may start while it waits. The flag store is not cleared after
// reset; only flags read at positions below the loaded length are ever used.
module polya_tail_detector #(
  parameter int unsigned ADDR_BITS = ptd_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire ptd_pkg::in_t                   in_data_i,
  output logic                                in_stall_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output ptd_pkg::out_t                       out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ptd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ptd_pkg::*;

  ctl_t                 ctl;
  stat_t                stat;
  logic                 mem_we, mem_wdata, mem_re, mem_rdata;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;

  ptd_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  ptd_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ptd_flag_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  `PTD_ASSERT_NEXT(a_query_leaves_idle,
                   in_valid_i && !in_stall_o && in_data_i.command == CMD_QUERY, in_stall_o)
  `PTD_ASSERT_IMPL(a_write_only_idle, mem_we, ctl.accept)
  `PTD_ASSERT_IMPL(a_read_only_busy, mem_re, !ctl.accept)
  `PTD_ASSERT_IMPL(a_tail_needs_long, out_valid_o && out_data_o.has_tail, out_data_o.is_long)

endmodule

`default_nettype wire

// ===== rtl/core/ptd_flag_mem.sv =====
// A/T flag store: one bit per genome position, one write and one registered read port.
// Depends on ptd_pkg for the default address width.
`default_nettype none

module ptd_flag_mem #(
  parameter int unsigned ADDR_BITS = ptd_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic                 wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic                      rdata_o
);
  logic mem [2**ADDR_BITS];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ptd_sequencer.sv =====
// Microcode sequencer: step counter, program table from ptd_pkg, conditional jumps.
// Depends on ptd_pkg.
`default_nettype none

module ptd_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ptd_pkg::stat_t stat_i,
  output ptd_pkg::ctl_t      ctl_o
);
  import ptd_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctl_t            ctl;
  logic            take;

  assign ctl = ucode(pc_q);

  always_comb begin
    unique case (ctl.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_QUERY:   take = !stat_i.query_acc;
      C_FLAG:       take = stat_i.flag;
      C_NOT_LONG:   take = !stat_i.is_long;
      C_TAIL:       take = stat_i.tail_hit;
      C_RETRY_DONE: take = stat_i.retry_done;
      C_OUT_BUSY:   take = stat_i.out_busy;
      default:      take = 1'b1;
    endcase
    pc_d = take ? ctl.target : pc_q + {{(PC_W-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o = ctl;

endmodule

`default_nettype wire

// ===== rtl/core/ptd_datapath.sv =====
// Datapath: config registers, genome length, walk positions, retry state, output register.
// Depends on ptd_pkg; driven by ptd_sequencer control words, talks to ptd_flag_mem.
`default_nettype none

module ptd_datapath #(
  parameter int unsigned ADDR_BITS = ptd_pkg::ADDR_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire ptd_pkg::in_t                       in_data_i,
  output logic                                    in_stall_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output ptd_pkg::out_t                           out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ptd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ptd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire ptd_pkg::ctl_t                      ctl_i,
  output ptd_pkg::stat_t                          stat_o,
  output logic                                    mem_we_o,
  output logic [ADDR_BITS-1:0]                    mem_waddr_o,
  output logic                                    mem_wdata_o,
  output logic                                    mem_re_o,
  output logic [ADDR_BITS-1:0]                    mem_raddr_o,
  input  wire logic                               mem_rdata_i
);
  import ptd_pkg::*;

  localparam int unsigned PW = ((ADDR_BITS > 21) ? ADDR_BITS : 21) + 2;
  localparam logic [ADDR_BITS:0] CAP = {1'b1, {ADDR_BITS{1'b0}}};

  logic [THR_W-1:0]    thr_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [RCNT_W-1:0]   rcnt_q;
  logic [MINLEN_W-1:0] minlen_q;
  logic [ADDR_BITS:0]  len_q, len_d;
  logic                ovf_q;

  logic signed [PW-1:0] anchor_q, lo_q, hi_q;
  logic                 minus_q, long_q, tail_q, inrange_q;
  logic [RCNT_W-1:0]    k_q;
  logic                 out_valid_q;
  out_t                 out_q;

  logic                 in_acc, ld, qry, rst_cmd, full, is_at, flag, out_busy, tail_hit;
  logic signed [POS_W:0] diff;
  logic                 long_d;
  logic signed [PW-1:0] anchor_in, shift_ext, rd_pos, len_s, span, thr_ext;

  assign in_stall_o = !ctl_i.accept;
  assign in_acc     = in_valid_i && ctl_i.accept;
  assign ld         = in_acc && (in_data_i.command == CMD_LOAD);
  assign qry        = in_acc && (in_data_i.command == CMD_QUERY);
  assign rst_cmd    = in_acc && (in_data_i.command == CMD_RESTART);

  assign full  = (len_q == CAP);
  assign is_at = (in_data_i.base == CH_A_UP) || (in_data_i.base == CH_A_LO) ||
                 (in_data_i.base == CH_T_UP) || (in_data_i.base == CH_T_LO);

  assign mem_we_o    = ld && !full;
  assign mem_waddr_o = len_q[ADDR_BITS-1:0];
  assign mem_wdata_o = is_at;

  always_comb begin
    len_d = len_q;
    if (rst_cmd) begin
      len_d = '0;
    end else if (ld && !full) begin
      len_d = len_q + {{ADDR_BITS{1'b0}}, 1'b1};
    end
  end

  assign diff   = $signed({1'b0, in_data_i.rep_end}) - $signed({1'b0, in_data_i.rep_start});
  assign long_d = diff > $signed({1'b0, minlen_q});
  assign anchor_in = in_data_i.strand ? $signed({{(PW-POS_W){1'b0}}, in_data_i.rep_start})
                                      : $signed({{(PW-POS_W){1'b0}}, in_data_i.rep_end});
  assign shift_ext = $signed({{(PW-SHIFT_W){1'b0}}, shift_q});
  assign thr_ext   = $signed({{(PW-THR_W){1'b0}}, thr_q});
  assign len_s     = $signed({{(PW-ADDR_BITS-1){1'b0}}, len_q});

  assign rd_pos      = ctl_i.rd_hi ? hi_q : lo_q;
  assign mem_re_o    = ctl_i.rd_en;
  assign mem_raddr_o = rd_pos[ADDR_BITS-1:0];
  assign flag        = inrange_q && mem_rdata_i;

  assign span     = hi_q - lo_q;
  assign tail_hit = span > thr_ext;
  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      shift_q  <= SHIFT_RST;
      rcnt_q   <= RCNT_RST;
      minlen_q <= MINLEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TAIL_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        CFG_RETRY_SHIFT:    shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_RETRY_COUNT:    rcnt_q   <= cfg_data_i[RCNT_W-1:0];
        CFG_MIN_REPEAT_LEN: minlen_q <= cfg_data_i[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (ld && full) begin
        ovf_q <= 1'b1;
      end
      if (ctl_i.emit && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry) begin
      anchor_q <= anchor_in;
      minus_q  <= in_data_i.strand;
      long_q   <= long_d;
      tail_q   <= 1'b0;
      k_q      <= '0;
    end
    if (ctl_i.retry) begin
      anchor_q <= minus_q ? anchor_q - shift_ext : anchor_q + shift_ext;
      k_q      <= k_q + {{(RCNT_W-1){1'b0}}, 1'b1};
    end
    if (ctl_i.chk) begin
      tail_q <= tail_hit;
    end
    if (ctl_i.init) begin
      lo_q <= anchor_q;
      hi_q <= anchor_q + $signed({{(PW-1){1'b0}}, 1'b1});
    end else begin
      if (ctl_i.lo_op == P_STEP || (ctl_i.lo_op == P_STEP_FLAG && flag)) begin
        lo_q <= lo_q - $signed({{(PW-1){1'b0}}, 1'b1});
      end
      if (ctl_i.hi_op == P_STEP || (ctl_i.hi_op == P_STEP_FLAG && flag)) begin
        hi_q <= hi_q + $signed({{(PW-1){1'b0}}, 1'b1});
      end
    end
    if (ctl_i.rd_en) begin
      inrange_q <= !rd_pos[PW-1] && (rd_pos < len_s);
    end
    if (ctl_i.emit && !out_busy) begin
      out_q.is_long    <= long_q;
      out_q.has_tail   <= long_q && tail_q;
      out_q.overflowed <= ovf_q;
    end
  end

  assign stat_o = '{query_acc: qry, is_long: long_q, flag: flag, tail_hit: tail_hit,
                    retry_done: (k_q == rcnt_q), out_busy: out_busy};

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
